// ===== hw/rtl/xcfr_pkg.sv =====
// Package for the XOR-checked frame receiver.
// Shared constants, register codes and controller/datapath structs.
// No dependencies.
package xcfr_pkg;

	localparam int DATA_MAX_DEF = 32;
	localparam int LEN_MIN      = 2;
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;

	localparam logic [1:0] REG_FIRST_HEADER  = 2'd0;
	localparam logic [1:0] REG_SECOND_HEADER = 2'd1;
	localparam logic [1:0] REG_END_MARKER    = 2'd2;

	typedef struct packed {
		logic [7:0] first_header;
		logic [7:0] second_header;
		logic [7:0] end_marker;
	} cfg_t;

	typedef struct packed {
		logic load_len;
		logic load_cmd;
		logic store_data;
		logic rd_clr;
		logic rd_issue;
		logic out_load;
		logic out_empty;
	} cmd_t;

	typedef struct packed {
		logic hdr1_match;
		logic hdr2_match;
		logic len_ok;
		logic len_zero;
		logic data_done;
		logic cs_match;
		logic end_match;
		logic last_rd;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/xcfr_in_if.sv =====
// Input channel interface: one received byte per word.
// Depends on nothing.
interface xcfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/xcfr_out_if.sv =====
// Result channel interface: one payload word per handshake.
// Depends on nothing.
interface xcfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] command;
	logic [5:0] payload_length;
	logic [4:0] byte_index;
	logic [7:0] payload_byte;
	logic       data_present;
	logic       last;

	modport source (output valid, output command, output payload_length,
		output byte_index, output payload_byte, output data_present,
		output last, input ready);
	modport sink (input valid, input command, input payload_length,
		input byte_index, input payload_byte, input data_present,
		input last, output ready);
endinterface

// ===== hw/rtl/xcfr_regs.sv =====
// APB configuration registers of the frame receiver.
// Depends on xcfr_pkg.
module xcfr_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [xcfr_pkg::ADDR_W-1:0] paddr,
	input  logic [xcfr_pkg::DATA_W-1:0] pwdata,
	output logic [xcfr_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output xcfr_pkg::cfg_t              cfg
);
	xcfr_pkg::cfg_t cfg_q;
	logic [1:0]     reg_idx;
	logic           wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				xcfr_pkg::REG_FIRST_HEADER:  cfg_q.first_header  <= pwdata[7:0];
				xcfr_pkg::REG_SECOND_HEADER: cfg_q.second_header <= pwdata[7:0];
				xcfr_pkg::REG_END_MARKER:    cfg_q.end_marker    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			xcfr_pkg::REG_FIRST_HEADER:  prdata[7:0] = cfg_q.first_header;
			xcfr_pkg::REG_SECOND_HEADER: prdata[7:0] = cfg_q.second_header;
			xcfr_pkg::REG_END_MARKER:    prdata[7:0] = cfg_q.end_marker;
			default:                     prdata      = '0;
		endcase
	end
endmodule

// ===== hw/rtl/xcfr_ctrl.sv =====
// Frame receiver controller: frame phase sequencing and payload drain.
// Depends on xcfr_pkg.
module xcfr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  xcfr_pkg::sts_t     sts,
	output xcfr_pkg::cmd_t     cmd
);
	typedef enum logic [3:0] {
		ST_HEAD1,
		ST_HEAD2,
		ST_LEN,
		ST_CMD,
		ST_DATA,
		ST_CS,
		ST_END,
		ST_EMPTY,
		ST_RD,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   fire;

	assign in_ready = !(state_q inside {ST_EMPTY, ST_RD, ST_OUT});
	assign fire     = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LEN:   cmd.load_len   = fire && sts.len_ok;
			ST_CMD:   cmd.load_cmd   = fire;
			ST_DATA:  cmd.store_data = fire;
			ST_END:   cmd.rd_clr     = fire;
			ST_EMPTY: begin
				cmd.out_load  = sts.out_free;
				cmd.out_empty = 1'b1;
			end
			ST_RD:    cmd.rd_issue   = 1'b1;
			ST_OUT:   cmd.out_load   = sts.out_free;
			default:  cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEAD1;
		end else begin
			case (state_q)
				ST_HEAD1: if (fire && sts.hdr1_match) state_q <= ST_HEAD2;
				ST_HEAD2: if (fire) state_q <= sts.hdr2_match ? ST_LEN : ST_HEAD1;
				ST_LEN:   if (fire) state_q <= sts.len_ok ? ST_CMD : ST_HEAD1;
				ST_CMD:   if (fire) state_q <= sts.len_zero ? ST_CS : ST_DATA;
				ST_DATA:  if (fire && sts.data_done) state_q <= ST_CS;
				ST_CS:    if (fire) state_q <= sts.cs_match ? ST_END : ST_HEAD1;
				ST_END: begin
					if (fire) begin
						if (!sts.end_match)   state_q <= ST_HEAD1;
						else if (sts.len_zero) state_q <= ST_EMPTY;
						else                  state_q <= ST_RD;
					end
				end
				ST_EMPTY: if (sts.out_free) state_q <= ST_HEAD1;
				ST_RD:    state_q <= ST_OUT;
				ST_OUT: begin
					if (sts.out_free) state_q <= sts.last_rd ? ST_HEAD1 : ST_RD;
				end
				default:  state_q <= ST_HEAD1;
			endcase
		end
	end
endmodule

// ===== hw/rtl/xcfr_dp.sv =====
// Frame receiver datapath: length/command/checksum registers, payload
// memory and the result output register. Depends on xcfr_pkg.
module xcfr_dp #(
	parameter int DATA_MAX = xcfr_pkg::DATA_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     rx_byte,
	input  xcfr_pkg::cfg_t cfg,
	input  xcfr_pkg::cmd_t cmd,
	output xcfr_pkg::sts_t sts,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     command,
	output logic [5:0]     payload_length,
	output logic [4:0]     byte_index,
	output logic [7:0]     payload_byte,
	output logic           data_present,
	output logic           last
);
	localparam int CntW  = $clog2(DATA_MAX + 1);
	localparam int AddrW = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;
	localparam logic [7:0] LenMin = 8'(xcfr_pkg::LEN_MIN);
	localparam logic [7:0] LenMax = 8'(DATA_MAX + xcfr_pkg::LEN_MIN);

	logic [7:0]      mem_q [DATA_MAX];
	logic [7:0]      rd_data_q;
	logic [7:0]      cmd_q;
	logic [CntW-1:0] exp_q;
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] rd_idx_q;
	logic [7:0]      xor_q;
	logic [CntW:0]   cnt_inc;
	logic [CntW:0]   rd_inc;
	logic [7:0]      len_sub;
	logic [7:0]      exp_ext;
	logic [7:0]      idx_ext;

	logic       out_valid_q;
	logic [7:0] command_q;
	logic [5:0] length_q;
	logic [4:0] index_q;
	logic [7:0] byte_q;
	logic       present_q;
	logic       last_q;

	assign cnt_inc = {1'b0, cnt_q} + 1'b1;
	assign rd_inc  = {1'b0, rd_idx_q} + 1'b1;
	assign len_sub = rx_byte - LenMin;
	assign exp_ext = 8'(exp_q);
	assign idx_ext = 8'(rd_idx_q);

	assign sts.hdr1_match = rx_byte == cfg.first_header;
	assign sts.hdr2_match = rx_byte == cfg.second_header;
	assign sts.len_ok     = (rx_byte >= LenMin) && (rx_byte <= LenMax);
	assign sts.len_zero   = exp_q == '0;
	assign sts.data_done  = cnt_inc >= {1'b0, exp_q};
	assign sts.cs_match   = xor_q == rx_byte;
	assign sts.end_match  = rx_byte == cfg.end_marker;
	assign sts.last_rd    = rd_inc == {1'b0, exp_q};
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= '0;
			exp_q    <= '0;
			cnt_q    <= '0;
			xor_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.load_len) begin
				exp_q <= len_sub[CntW-1:0];
				cnt_q <= '0;
				xor_q <= rx_byte;
			end
			if (cmd.load_cmd) begin
				cmd_q <= rx_byte;
				xor_q <= xor_q ^ rx_byte;
			end
			if (cmd.store_data) begin
				cnt_q <= cnt_inc[CntW-1:0];
				xor_q <= xor_q ^ rx_byte;
			end
			if (cmd.rd_clr) begin
				rd_idx_q <= '0;
			end else if (cmd.out_load && !cmd.out_empty) begin
				rd_idx_q <= rd_inc[CntW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_data && (cnt_q < CntW'(DATA_MAX))) begin
			mem_q[cnt_q[AddrW-1:0]] <= rx_byte;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem_q[rd_idx_q[AddrW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			command_q <= cmd_q;
			if (cmd.out_empty) begin
				length_q  <= '0;
				index_q   <= '0;
				byte_q    <= '0;
				present_q <= 1'b0;
				last_q    <= 1'b1;
			end else begin
				length_q  <= exp_ext[5:0];
				index_q   <= idx_ext[4:0];
				byte_q    <= rd_data_q;
				present_q <= 1'b1;
				last_q    <= sts.last_rd;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign command        = command_q;
	assign payload_length = length_q;
	assign byte_index     = index_q;
	assign payload_byte   = byte_q;
	assign data_present   = present_q;
	assign last           = last_q;
endmodule

// ===== hw/rtl/xor_checked_frame_receiver.sv =====
// Top level of the XOR-checked frame receiver.
// Depends on xcfr_pkg, xcfr_in_if, xcfr_out_if, xcfr_regs, xcfr_ctrl, xcfr_dp.
//
// Usage:
//   rx_ch takes one received byte per word. Frames are: first header,
//   second header, length L (2..DATA_MAX+2), command, L-2 data bytes,
//   XOR of length/command/data, end marker. The three marker values sit
//   in APB registers at 0x0, 0x4 and 0x8; write them while idle.
//   While a frame is being received a byte is taken every cycle.
//   After a good end marker the input is held off (ready low) while the
//   payload drains from the payload memory: each word on res_ch takes a
//   memory read, then an output register load, and the load waits while
//   the output register holds an untaken word. An empty frame gives one
//   word with data_present low.
//   Bad frames produce nothing. If res_ch stalls, the output register
//   holds its word and the drain pauses; the last word may wait there while
//   the next frame's bytes are already being taken.
//   Reset returns the block to header hunt, clears the registers to zero
//   and drops any pending result.
module xor_checked_frame_receiver #(
	parameter int DATA_MAX = xcfr_pkg::DATA_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	xcfr_in_if.sink                     rx_ch,
	xcfr_out_if.source                  res_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [xcfr_pkg::ADDR_W-1:0] paddr,
	input  logic [xcfr_pkg::DATA_W-1:0] pwdata,
	output logic [xcfr_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	xcfr_pkg::cfg_t cfg;
	xcfr_pkg::cmd_t cmd;
	xcfr_pkg::sts_t sts;

	xcfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	xcfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx_ch.valid),
		.in_ready (rx_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	xcfr_dp #(
		.DATA_MAX (DATA_MAX)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_byte        (rx_ch.rx_byte),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (res_ch.valid),
		.out_ready      (res_ch.ready),
		.command        (res_ch.command),
		.payload_length (res_ch.payload_length),
		.byte_index     (res_ch.byte_index),
		.payload_byte   (res_ch.payload_byte),
		.data_present   (res_ch.data_present),
		.last           (res_ch.last)
	);
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for xor_checked_frame_receiver: byte frames in, payload words out.
// A behavioral copy of the deframer predicts each word, and the words are checked in order.
// Depends on xcfr_pkg, xcfr_in_if, xcfr_out_if and the RTL top level.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DMAX   = xcfr_pkg::DATA_MAX_DEF;
	localparam int SETTLE = 100;

	typedef enum logic [2:0] {
		HUNT_H1, HUNT_H2, GET_LEN, GET_CMD, GET_DATA, GET_CSUM, GET_END
	} rx_phase_t;

	typedef enum int {
		FLAW_NONE, FLAW_HDR2, FLAW_LEN, FLAW_CSUM, FLAW_END, FLAW_CUT
	} flaw_t;

	typedef struct packed {
		logic [7:0] command;
		logic [5:0] payload_length;
		logic [4:0] byte_index;
		logic [7:0] payload_byte;
		logic       data_present;
		logic       last;
	} frame_word_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel, penable, pwrite;
	logic [xcfr_pkg::ADDR_W-1:0] paddr;
	logic [xcfr_pkg::DATA_W-1:0] pwdata, prdata;
	logic                        pready;

	xcfr_in_if  rx_ch ();
	xcfr_out_if res_ch ();

	xor_checked_frame_receiver uut (
		.clk(clk), .arst_n(arst_n), .rx_ch(rx_ch), .res_ch(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// marker mirror and deframer state
	logic [7:0]  cfg_first = 8'd0, cfg_second = 8'd0, cfg_end = 8'd0;
	rx_phase_t   ph = HUNT_H1;
	logic [7:0]  payload_mem [DMAX];
	logic [7:0]  held_cmd = 8'd0;
	logic [7:0]  csum_acc = 8'd0;
	int          want_len = 0, got_cnt = 0;

	frame_word_t words_due [$];
	logic [7:0]  byte_q [$];

	int rx_gap = 0, res_wait = 0;
	bit rx_hs = 1'b0, quiet = 1'b0;
	int err_cnt = 0, words_seen = 0, frames_seen = 0;
	int bytes_gen = 0, words_gen = 0, setups = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] other_than(input logic [7:0] v);
		return v ^ 8'($urandom_range(1, 255));
	endfunction

	function automatic string word_str(input frame_word_t w);
		return $sformatf("cmd=%h len=%0d idx=%0d data=%h present=%b last=%b", w.command,
			w.payload_length, w.byte_index, w.payload_byte, w.data_present, w.last);
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		frame_word_t w;
		case (ph)
			HUNT_H1: begin
				if (b == cfg_first)
					ph = HUNT_H2;
			end
			HUNT_H2: begin
				ph = (b == cfg_second) ? GET_LEN : HUNT_H1;
			end
			GET_LEN: begin
				got_cnt = 0;
				if (b < xcfr_pkg::LEN_MIN || b > DMAX + xcfr_pkg::LEN_MIN) begin
					ph = HUNT_H1;
				end else begin
					want_len = b - xcfr_pkg::LEN_MIN;
					csum_acc = b;
					ph = GET_CMD;
				end
			end
			GET_CMD: begin
				held_cmd = b;
				csum_acc ^= b;
				ph = (want_len > 0) ? GET_DATA : GET_CSUM;
			end
			GET_DATA: begin
				payload_mem[got_cnt] = b;
				got_cnt++;
				csum_acc ^= b;
				if (got_cnt >= want_len)
					ph = GET_CSUM;
			end
			GET_CSUM: begin
				if (csum_acc == b) begin
					ph = GET_END;
				end else begin
					ph = HUNT_H1;
					got_cnt = 0;
				end
			end
			GET_END: begin
				if (b == cfg_end) begin
					frames_seen++;
					if (want_len == 0) begin
						w = '{command: held_cmd, payload_length: 6'd0, byte_index: 5'd0,
							payload_byte: 8'd0, data_present: 1'b0, last: 1'b1};
						words_due.push_back(w);
					end else begin
						for (int k = 0; k < want_len; k++) begin
							w = '{command: held_cmd, payload_length: 6'(want_len),
								byte_index: 5'(k), payload_byte: payload_mem[k],
								data_present: 1'b1, last: (k == want_len - 1)};
							words_due.push_back(w);
						end
					end
				end
				ph = HUNT_H1;
				got_cnt = 0;
			end
			default: begin
				ph = (b == cfg_first) ? HUNT_H2 : HUNT_H1;
			end
		endcase
	endtask

	task automatic check_word();
		frame_word_t got, want;
		got = {res_ch.command, res_ch.payload_length, res_ch.byte_index,
			res_ch.payload_byte, res_ch.data_present, res_ch.last};
		words_seen++;
		if (words_due.size() == 0) begin
			err_cnt++;
			$display("%0t: unexpected word %s", $time, word_str(got));
		end else begin
			want = words_due.pop_front();
			if (got !== want) begin
				err_cnt++;
				$display("%0t: word mismatch, expected %s, got %s", $time,
					word_str(want), word_str(got));
			end
		end
	endtask

	// sample at the rising edge
	always @(posedge clk) begin
		rx_hs <= arst_n && rx_ch.valid && rx_ch.ready;
		if (arst_n && rx_ch.valid && rx_ch.ready)
			deframe_byte(rx_ch.rx_byte);
		if (arst_n && res_ch.valid && res_ch.ready)
			check_word();
	end

	always @(negedge clk) begin
		if (arst_n && (!rx_ch.valid || rx_hs)) begin
			if (rx_gap > 0) begin
				rx_ch.valid <= 1'b0;
				rx_gap <= rx_gap - 1;
			end else if (byte_q.size() > 0) begin
				rx_ch.valid <= 1'b1;
				rx_ch.rx_byte <= byte_q.pop_front();
				rx_gap <= pick_gap(quiet);
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (res_wait > 0) begin
				res_ch.ready <= 1'b0;
				res_wait <= res_wait - 1;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					res_wait <= pick_gap(quiet);
			end
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			xcfr_pkg::REG_FIRST_HEADER: cfg_first = val;
			xcfr_pkg::REG_SECOND_HEADER: cfg_second = val;
			xcfr_pkg::REG_END_MARKER: cfg_end = val;
			default: ;
		endcase
	endtask

	task automatic set_markers(input logic [7:0] h1, input logic [7:0] h2,
		input logic [7:0] e);
		apb_write(xcfr_pkg::REG_FIRST_HEADER, h1);
		apb_write(xcfr_pkg::REG_SECOND_HEADER, h2);
		apb_write(xcfr_pkg::REG_END_MARKER, e);
		setups++;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (byte_q.size() != 0 || rx_ch.valid)
			@(posedge clk);
		@(negedge clk);
		while (words_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put(input logic [7:0] b);
		byte_q.push_back(b);
		bytes_gen++;
	endtask

	task automatic queue_frame(input int n_data, input flaw_t flaw, input logic [7:0] cmd);
		logic [7:0] fb [$];
		logic [7:0] sum, d, bad_len;
		int keep;
		case ($urandom_range(0, 3))
			0: bad_len = 8'd0;
			1: bad_len = 8'd1;
			2: bad_len = 8'(DMAX + xcfr_pkg::LEN_MIN + 1);
			default: bad_len = 8'($urandom_range(DMAX + xcfr_pkg::LEN_MIN + 1, 255));
		endcase
		sum = 8'(n_data + xcfr_pkg::LEN_MIN);
		fb.push_back(cfg_first);
		fb.push_back(flaw == FLAW_HDR2 ? other_than(cfg_second) : cfg_second);
		fb.push_back(flaw == FLAW_LEN ? bad_len : sum);
		fb.push_back(cmd);
		sum ^= cmd;
		for (int i = 0; i < n_data; i++) begin
			d = ($urandom_range(0, 9) == 0) ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom);
			fb.push_back(d);
			sum ^= d;
		end
		fb.push_back(flaw == FLAW_CSUM ? other_than(sum) : sum);
		fb.push_back(flaw == FLAW_END ? other_than(cfg_end) : cfg_end);
		if (flaw == FLAW_CUT) begin
			keep = $urandom_range(1, fb.size() - 1);
			while (fb.size() > keep)
				void'(fb.pop_back());
		end
		if (flaw == FLAW_NONE)
			words_gen += (n_data == 0) ? 1 : n_data;
		foreach (fb[i])
			put(fb[i]);
	endtask

	task automatic random_traffic(input int n_bytes, input int n_words);
		int b0, w0, r, n;
		flaw_t flaw;
		b0 = bytes_gen;
		w0 = words_gen;
		@(posedge clk);
		while (bytes_gen - b0 < n_bytes || words_gen - w0 < n_words) begin
			r = $urandom_range(0, 99);
			n = (r < 5) ? DMAX : (r < 20) ? $urandom_range(7, DMAX - 1) : $urandom_range(0, 6);
			flaw = ($urandom_range(0, 99) < 70) ? FLAW_NONE : flaw_t'($urandom_range(1, 5));
			queue_frame(n, flaw, 8'($urandom));
			// line noise between frames
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) byte_q.push_back(8'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'd0;
		res_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_markers(8'hA5, 8'h5A, 8'h0D);
		@(posedge clk);
		put(cfg_first);
		put(cfg_first);                  // bad second header, not retried as first
		queue_frame(0, FLAW_NONE, 8'hFF);
		put(cfg_first);
		put(cfg_second);
		put(cfg_first);                  // out-of-range length equal to first header
		queue_frame(1, FLAW_NONE, 8'h00);
		queue_frame(0, FLAW_CSUM, 8'h3C);
		queue_frame(0, FLAW_END, 8'hC3);
		wait_idle();

		set_markers(8'h00, 8'h00, 8'h00);
		quiet = 1'b1;
		@(posedge clk);
		queue_frame(DMAX, FLAW_NONE, 8'h81);
		random_traffic(20, 6);
		wait_idle();

		quiet = 1'b0;
		set_markers(8'hFF, 8'hFF, 8'hFF);
		random_traffic(20, 6);
		wait_idle();

		set_markers(8'($urandom), 8'($urandom), 8'($urandom));
		random_traffic(20, 6);
		wait_idle();

		$display("Ran %0d marker settings and %0d frame bytes, with bad headers, lengths,",
			setups, bytes_gen);
		$display("checksums, end markers and cut frames: %0d frames and %0d words seen.",
			frames_seen, words_seen);
		if (err_cnt == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout at %0t", $time);
		$display("testbench failed");
		$finish;
	end

endmodule
